FILE: sv/jps_pkg.sv
// jps_pkg: shared types, constants and codes of the 1d poisson jacobi solver
// no dependencies; used by jps_alu, jps_seq and the top level by scoped names
package jps_pkg;

	// grid geometry
	localparam int GRID_POINTS = 128;
	localparam int IDX_W       = $clog2(GRID_POINTS);
	localparam logic [IDX_W-1:0] N_MAX = IDX_W'(GRID_POINTS - 2);

	// field widths
	localparam int VALUE_W = 32;
	localparam int H2_W    = 17;
	localparam int TOL_W   = 31;
	localparam int ITER_W  = 17;
	localparam int NPTS_W  = 7;
	localparam int CHG_W   = 32;

	// datapath widths: 18x32 signed product, accumulator with headroom
	localparam int PROD_W    = H2_W + 1 + VALUE_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int FRAC_BITS = 16;

	localparam logic signed [ACC_W-1:0] ROUND_C  = ACC_W'(2 ** FRAC_BITS);
	localparam logic signed [ACC_W-1:0] VAL_MAX  = ACC_W'((64'sd1 <<< (VALUE_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] VAL_MIN  = -VAL_MAX - ACC_W'(1);
	localparam logic [ITER_W-1:0]       SWEEP_CAP = ITER_W'(65536);
	localparam logic [TOL_W-1:0]        CHG_CAP   = {TOL_W{1'b1}};

	// register reset values
	localparam logic [H2_W-1:0]   H2_RST   = H2_W'(6);
	localparam logic [TOL_W-1:0]  TOL_RST  = TOL_W'(1);
	localparam logic [ITER_W-1:0] ITER_RST = ITER_W'(65536);
	localparam logic [NPTS_W-1:0] NPTS_RST = NPTS_W'(100);

	// configuration port
	localparam int PADDR_W = 4;

	typedef enum logic [1:0] {
		REG_H2     = 2'd0,
		REG_TOL    = 2'd1,
		REG_ITER   = 2'd2,
		REG_POINTS = 2'd3
	} reg_t;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_SOLVE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_EDGE0,
		ST_EDGE1,
		ST_MUL,
		ST_SUM,
		ST_UPD,
		ST_NEXT,
		ST_DONE
	} state_t;

	// sequencer to datapath and memories
	typedef struct packed {
		logic             left_ld;
		logic             mid_ld;
		logic             mul_ld;
		logic             sum_ld;
		logic             upd;
		logic             du_clr;
		logic             respond;
		logic             read_done;
		logic             finish;
		logic             sol_we;
		logic             load_sel;
		logic             src_we;
		logic [IDX_W-1:0] wr_addr;
		logic [IDX_W-1:0] sol_raddr;
		logic [IDX_W-1:0] src_raddr;
	} ctl_t;

endpackage

FILE: sv/jps_ram.sv
// jps_ram: generic single write port, single read port ram with registered read
// no dependencies
module jps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/jps_alu.sv
// jps_alu: shared point update unit (multiply, sum and round, change tracking)
// depends on jps_pkg; driven step by step by jps_seq
module jps_alu (
	input  logic                               clk,
	input  logic                               arst_n,
	input  jps_pkg::ctl_t                      ctl,
	input  logic signed [jps_pkg::VALUE_W-1:0] u_rdata,
	input  logic signed [jps_pkg::VALUE_W-1:0] f_rdata,
	input  logic [jps_pkg::H2_W-1:0]           h2,
	input  logic [jps_pkg::TOL_W-1:0]          tol,
	output logic signed [jps_pkg::VALUE_W-1:0] nv,
	output logic [jps_pkg::CHG_W-1:0]          du,
	output logic                               below_tol
);

	// old values around the point: u[i-1], u[i], u[i+1]
	logic signed [jps_pkg::VALUE_W-1:0] left_q, mid_q, right_q;
	logic signed [jps_pkg::PROD_W-1:0]  prod_s1;
	logic signed [jps_pkg::VALUE_W-1:0] nv_s2;
	logic [jps_pkg::CHG_W-1:0]          du_q;

	logic signed [jps_pkg::PROD_W-1:0]    prod;
	logic signed [jps_pkg::ACC_W-1:0]     pair, acc, shifted;
	logic signed [jps_pkg::VALUE_W-1:0]   nv_d;
	logic signed [jps_pkg::VALUE_W:0]     diff;
	logic [jps_pkg::CHG_W-1:0]            absd;

	// h2 * f, unsigned h2 widened to a signed operand
	assign prod = $signed({1'b0, h2}) * f_rdata;

	// (l + r) * 2^16 - h2*f, round half up, divide by 2^17, saturate
	always_comb begin
		pair    = jps_pkg::ACC_W'(left_q) + jps_pkg::ACC_W'(right_q);
		acc     = (pair <<< jps_pkg::FRAC_BITS) - jps_pkg::ACC_W'(prod_s1) + jps_pkg::ROUND_C;
		shifted = acc >>> (jps_pkg::FRAC_BITS + 1);
		if (shifted > jps_pkg::VAL_MAX) begin
			nv_d = jps_pkg::VALUE_W'(jps_pkg::VAL_MAX);
		end else if (shifted < jps_pkg::VAL_MIN) begin
			nv_d = jps_pkg::VALUE_W'(jps_pkg::VAL_MIN);
		end else begin
			nv_d = shifted[jps_pkg::VALUE_W-1:0];
		end
	end

	// exact absolute change of the point
	always_comb begin
		diff = (jps_pkg::VALUE_W+1)'(nv_s2) - (jps_pkg::VALUE_W+1)'(mid_q);
		if (diff[jps_pkg::VALUE_W]) begin
			absd = jps_pkg::CHG_W'(-diff);
		end else begin
			absd = diff[jps_pkg::CHG_W-1:0];
		end
	end

	// operand window and pipeline registers
	always_ff @(posedge clk) begin
		if (ctl.left_ld) begin
			left_q <= u_rdata;
		end
		if (ctl.mid_ld) begin
			mid_q <= u_rdata;
		end
		if (ctl.mul_ld) begin
			right_q <= u_rdata;
			prod_s1 <= prod;
		end
		if (ctl.sum_ld) begin
			nv_s2 <= nv_d;
		end
		if (ctl.upd) begin
			left_q <= mid_q;
			mid_q  <= right_q;
		end
	end

	// running maximum change of the sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			du_q <= '0;
		end else if (ctl.du_clr) begin
			du_q <= '0;
		end else if (ctl.upd && (absd > du_q)) begin
			du_q <= absd;
		end
	end

	assign nv        = nv_s2;
	assign du        = du_q;
	assign below_tol = du_q < {1'b0, tol};

endmodule

FILE: sv/jps_seq.sv
// jps_seq: request decode and sweep sequencer of the jacobi solver
// depends on jps_pkg; steers jps_alu and the two grid rams
module jps_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  jps_pkg::cmd_t                   command,
	input  logic [jps_pkg::IDX_W-1:0]       grid_index,
	input  logic [jps_pkg::NPTS_W-1:0]      points_cfg,
	input  logic [jps_pkg::ITER_W-1:0]      iter_cfg,
	input  logic                            below_tol,
	output jps_pkg::ctl_t                   ctl,
	output logic                            busy,
	output logic [jps_pkg::ITER_W-1:0]      sweeps,
	output logic                            conv
);

	jps_pkg::state_t state_q, state_d;

	logic [jps_pkg::IDX_W-1:0]  i_q, n_q;
	logic [jps_pkg::ITER_W-1:0] k_q, limit_q;
	logic                       conv_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and step controls
	always_comb begin
		state_d       = state_q;
		ctl           = '0;
		ctl.wr_addr   = i_q;
		ctl.sol_raddr = i_q + jps_pkg::IDX_W'(1);
		ctl.src_raddr = i_q;
		unique case (state_q)
			jps_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (command)
						jps_pkg::CMD_LOAD: begin
							ctl.sol_we   = 1'b1;
							ctl.src_we   = 1'b1;
							ctl.load_sel = 1'b1;
							ctl.wr_addr  = grid_index;
							ctl.respond  = 1'b1;
						end
						jps_pkg::CMD_SOLVE: begin
							ctl.du_clr = 1'b1;
							state_d    = jps_pkg::ST_CHECK;
						end
						jps_pkg::CMD_READ: begin
							ctl.sol_raddr = grid_index;
							state_d       = jps_pkg::ST_READ;
						end
						jps_pkg::CMD_NOP: begin
							ctl.respond = 1'b1;
						end
					endcase
				end
			end
			jps_pkg::ST_READ: begin
				ctl.read_done = 1'b1;
				state_d       = jps_pkg::ST_IDLE;
			end
			jps_pkg::ST_CHECK: begin
				if (k_q >= limit_q) begin
					state_d = jps_pkg::ST_DONE;
				end else begin
					ctl.du_clr    = 1'b1;
					ctl.sol_raddr = '0;
					state_d       = jps_pkg::ST_EDGE0;
				end
			end
			jps_pkg::ST_EDGE0: begin
				// u[0] arrives, fetch u[1]
				ctl.left_ld   = 1'b1;
				ctl.sol_raddr = jps_pkg::IDX_W'(1);
				state_d       = jps_pkg::ST_EDGE1;
			end
			jps_pkg::ST_EDGE1: begin
				// u[1] arrives, fetch u[2] and f[1]
				ctl.mid_ld = 1'b1;
				if (n_q == '0) begin
					state_d = jps_pkg::ST_NEXT;
				end else begin
					state_d = jps_pkg::ST_MUL;
				end
			end
			jps_pkg::ST_MUL: begin
				ctl.mul_ld = 1'b1;
				state_d    = jps_pkg::ST_SUM;
			end
			jps_pkg::ST_SUM: begin
				ctl.sum_ld = 1'b1;
				state_d    = jps_pkg::ST_UPD;
			end
			jps_pkg::ST_UPD: begin
				// write back u[i], prefetch for the next point
				ctl.upd       = 1'b1;
				ctl.sol_we    = 1'b1;
				ctl.sol_raddr = i_q + jps_pkg::IDX_W'(2);
				ctl.src_raddr = i_q + jps_pkg::IDX_W'(1);
				if (i_q == n_q) begin
					state_d = jps_pkg::ST_NEXT;
				end else begin
					state_d = jps_pkg::ST_MUL;
				end
			end
			jps_pkg::ST_NEXT: begin
				if (below_tol) begin
					state_d = jps_pkg::ST_DONE;
				end else begin
					state_d = jps_pkg::ST_CHECK;
				end
			end
			jps_pkg::ST_DONE: begin
				ctl.finish = 1'b1;
				state_d    = jps_pkg::ST_IDLE;
			end
			default: begin
				state_d = jps_pkg::ST_IDLE;
			end
		endcase
	end

	// point index, sweep count and solve parameters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			n_q     <= '0;
			k_q     <= '0;
			limit_q <= '0;
			conv_q  <= 1'b0;
		end else begin
			if ((state_q == jps_pkg::ST_IDLE) && accept && (command == jps_pkg::CMD_SOLVE)) begin
				n_q     <= (points_cfg > jps_pkg::N_MAX) ? jps_pkg::N_MAX : points_cfg;
				limit_q <= (iter_cfg > jps_pkg::SWEEP_CAP) ? jps_pkg::SWEEP_CAP : iter_cfg;
				k_q     <= '0;
				conv_q  <= 1'b0;
			end
			if (state_q == jps_pkg::ST_CHECK) begin
				i_q <= jps_pkg::IDX_W'(1);
			end
			if ((state_q == jps_pkg::ST_UPD) && (i_q != n_q)) begin
				i_q <= i_q + jps_pkg::IDX_W'(1);
			end
			if (state_q == jps_pkg::ST_NEXT) begin
				k_q <= k_q + jps_pkg::ITER_W'(1);
				if (below_tol) begin
					conv_q <= 1'b1;
				end
			end
		end
	end

	assign busy   = (state_q != jps_pkg::ST_IDLE);
	assign sweeps = k_q;
	assign conv   = conv_q;

	// sweep writes stay on interior points
	a_upd_interior: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == jps_pkg::ST_UPD) |-> ((i_q != '0) && (i_q <= n_q)))
		else $error("sweep write outside interior points");

	// sweep count never passes the limit while solving
	a_k_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == jps_pkg::ST_CHECK) |-> (k_q <= limit_q))
		else $error("sweep count beyond limit");

	// a converged solve has done at least one sweep
	a_conv_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == jps_pkg::ST_DONE) && conv_q) |-> (k_q != '0))
		else $error("converged with no sweep");

	// the sequencer takes no request while busy
	a_idle_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (state_q != jps_pkg::ST_IDLE)) |-> 1'b0)
		else $error("request accepted while busy");

endmodule

FILE: sv/jacobi_poisson_1d_solver.sv
// jacobi_poisson_1d_solver: top level, config registers, grid rams, result register
// depends on jps_pkg, jps_ram, jps_alu and jps_seq
//
// channel   signals                               direction
// request   request_valid/request_stall + fields  in
// result    result_valid/result_stall + fields    out
// config    psel/penable/pwrite/paddr/pwdata      in, prdata/pready out
//
// load and no-action requests are answered from idle; a read goes through the ram read port.
// a solve runs every sweep on one shared point unit, in mul, sum and upd steps per point.
// reset clears control, config and status registers only; grid rams hold nothing valid until loaded.
// request_stall is high while a read or solve runs and while a result waits stalled.
module jacobi_poisson_1d_solver (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [jps_pkg::PADDR_W-1:0]         paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                request_valid,
	output logic                                request_stall,
	input  logic [1:0]                          command,
	input  logic [6:0]                          grid_index,
	input  logic signed [jps_pkg::VALUE_W-1:0]  source_value,
	input  logic signed [jps_pkg::VALUE_W-1:0]  initial_value,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [jps_pkg::VALUE_W-1:0]  solution_value,
	output logic [jps_pkg::ITER_W-1:0]          sweeps_done,
	output logic                                converged,
	output logic [jps_pkg::TOL_W-1:0]           largest_change
);

	logic [jps_pkg::H2_W-1:0]   h2_q;
	logic [jps_pkg::TOL_W-1:0]  tol_q;
	logic [jps_pkg::ITER_W-1:0] iter_q;
	logic [jps_pkg::NPTS_W-1:0] npts_q;

	jps_pkg::reg_t reg_sel;
	logic          cfg_wr;

	jps_pkg::ctl_t ctl;
	logic          busy, accept, below_tol, seq_conv;
	logic [jps_pkg::ITER_W-1:0] seq_sweeps;

	logic signed [jps_pkg::VALUE_W-1:0] u_rdata, f_rdata, nv, sol_wdata;
	logic [jps_pkg::CHG_W-1:0]          du;

	logic [jps_pkg::ITER_W-1:0] sweeps_q, sweeps_nx;
	logic                       conv_q, conv_nx;
	logic [jps_pkg::TOL_W-1:0]  chg_q, chg_nx;

	logic                               res_valid_q;
	logic signed [jps_pkg::VALUE_W-1:0] res_value_q;
	logic [jps_pkg::ITER_W-1:0]         res_sweeps_q;
	logic                               res_conv_q;
	logic [jps_pkg::TOL_W-1:0]          res_chg_q;
	logic                               res_load;

	// configuration registers
	assign reg_sel = jps_pkg::reg_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h2_q   <= jps_pkg::H2_RST;
			tol_q  <= jps_pkg::TOL_RST;
			iter_q <= jps_pkg::ITER_RST;
			npts_q <= jps_pkg::NPTS_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				jps_pkg::REG_H2:     h2_q   <= pwdata[jps_pkg::H2_W-1:0];
				jps_pkg::REG_TOL:    tol_q  <= pwdata[jps_pkg::TOL_W-1:0];
				jps_pkg::REG_ITER:   iter_q <= pwdata[jps_pkg::ITER_W-1:0];
				jps_pkg::REG_POINTS: npts_q <= pwdata[jps_pkg::NPTS_W-1:0];
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_sel)
			jps_pkg::REG_H2:     prdata = 32'(h2_q);
			jps_pkg::REG_TOL:    prdata = 32'(tol_q);
			jps_pkg::REG_ITER:   prdata = 32'(iter_q);
			jps_pkg::REG_POINTS: prdata = 32'(npts_q);
		endcase
	end

	// request handshake
	assign request_stall = busy || (res_valid_q && result_stall);
	assign accept        = request_valid && !request_stall;

	jps_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (jps_pkg::cmd_t'(command)),
		.grid_index (grid_index),
		.points_cfg (npts_q),
		.iter_cfg   (iter_q),
		.below_tol  (below_tol),
		.ctl        (ctl),
		.busy       (busy),
		.sweeps     (seq_sweeps),
		.conv       (seq_conv)
	);

	jps_alu u_alu (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.u_rdata   (u_rdata),
		.f_rdata   (f_rdata),
		.h2        (h2_q),
		.tol       (tol_q),
		.nv        (nv),
		.du        (du),
		.below_tol (below_tol)
	);

	// grid memories
	assign sol_wdata = ctl.load_sel ? initial_value : nv;

	jps_ram #(
		.WIDTH (jps_pkg::VALUE_W),
		.DEPTH (jps_pkg::GRID_POINTS)
	) u_sol_ram (
		.clk   (clk),
		.we    (ctl.sol_we),
		.waddr (ctl.wr_addr),
		.wdata (sol_wdata),
		.raddr (ctl.sol_raddr),
		.rdata (u_rdata)
	);

	jps_ram #(
		.WIDTH (jps_pkg::VALUE_W),
		.DEPTH (jps_pkg::GRID_POINTS)
	) u_src_ram (
		.clk   (clk),
		.we    (ctl.src_we),
		.waddr (ctl.wr_addr),
		.wdata (source_value),
		.raddr (ctl.src_raddr),
		.rdata (f_rdata)
	);

	// status of the last solve
	always_comb begin
		sweeps_nx = sweeps_q;
		conv_nx   = conv_q;
		chg_nx    = chg_q;
		if (ctl.finish) begin
			sweeps_nx = seq_sweeps;
			conv_nx   = seq_conv;
			chg_nx    = du[jps_pkg::CHG_W-1] ? jps_pkg::CHG_CAP : du[jps_pkg::TOL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweeps_q <= '0;
			conv_q   <= 1'b0;
			chg_q    <= '0;
		end else begin
			sweeps_q <= sweeps_nx;
			conv_q   <= conv_nx;
			chg_q    <= chg_nx;
		end
	end

	// result register
	assign res_load = ctl.respond || ctl.read_done || ctl.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_value_q  <= ctl.read_done ? u_rdata : '0;
			res_sweeps_q <= sweeps_nx;
			res_conv_q   <= conv_nx;
			res_chg_q    <= chg_nx;
		end
	end

	assign result_valid   = res_valid_q;
	assign solution_value = res_value_q;
	assign sweeps_done    = res_sweeps_q;
	assign converged      = res_conv_q;
	assign largest_change = res_chg_q;

endmodule
